// File: rtl/core/lkv_pkg.sv
// Package for the LRU key/value cache: command and result transfer types and
// fixed constants shared by all modules. No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

  // Field widths fixed by the interface.
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;

  // Action codes.
  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Value returned by a get that misses.
  localparam logic signed [DATA_W-1:0] MISS_VALUE = '1;

  // One command transfer.
  typedef struct packed {
    logic                     action;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } lkv_cmd_t;

  // One result transfer.
  typedef struct packed {
    logic                     hit;
    logic signed [DATA_W-1:0] read_value;
  } lkv_result_t;

endpackage

// File: rtl/core/lkv_lookup.sv
// Parallel key match across all cache entries and hit data selection.
// Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_lookup #(
  parameter int ENTRIES = 16
) (
  input  logic [ENTRIES-1:0]                     entry_valid,
  input  logic [ENTRIES-1:0][lkv_pkg::DATA_W-1:0] entry_key,
  input  logic [ENTRIES-1:0][lkv_pkg::DATA_W-1:0] entry_value,
  input  logic [lkv_pkg::DATA_W-1:0]             key,
  output logic [ENTRIES-1:0]                     hit_vec,
  output logic                                   hit,
  output logic [lkv_pkg::DATA_W-1:0]             read_value
);

  logic [lkv_pkg::DATA_W-1:0] sel_value;

  // Compare every valid entry against the key at once.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i] = entry_valid[i] && (entry_key[i] == key);
    end
  end

  // Keys are unique among valid entries, so an OR of the masked values selects the hit.
  always_comb begin
    sel_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      sel_value = sel_value | (entry_value[i] & {lkv_pkg::DATA_W{hit_vec[i]}});
    end
  end

  assign hit        = |hit_vec;
  assign read_value = hit ? sel_value : lkv_pkg::MISS_VALUE;

endmodule

// File: rtl/core/lkv_store.sv
// Entry storage, recency ranks and occupancy for the LRU key/value cache,
// with slot choice and rank update for a set. Depends on lkv_pkg.
`timescale 1ns / 1ps

module lkv_store #(
  parameter int ENTRIES = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   upd_en,
  input  logic [lkv_pkg::DATA_W-1:0]             upd_key,
  input  logic [lkv_pkg::DATA_W-1:0]             upd_value,
  input  logic                                   hit,
  input  logic [ENTRIES-1:0]                     hit_vec,
  input  logic [lkv_pkg::CAP_W-1:0]              capacity,
  output logic [ENTRIES-1:0]                     entry_valid,
  output logic [ENTRIES-1:0][lkv_pkg::DATA_W-1:0] entry_key,
  output logic [ENTRIES-1:0][lkv_pkg::DATA_W-1:0] entry_value
);

  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);

  logic [ENTRIES-1:0]             valid;
  logic [ENTRIES-1:0][RANK_W-1:0] rank;
  logic [OCC_W-1:0]               occupancy;

  logic [31:0]                    eff_cap;
  logic                           full;
  logic [RANK_W-1:0]              last_rank;
  logic [RANK_W-1:0]              hit_rank;
  logic [ENTRIES-1:0]             free_vec;
  logic [ENTRIES-1:0]             victim_vec;
  logic [ENTRIES-1:0]             slot_vec;
  logic [ENTRIES-1:0]             inc_vec;

  // Effective capacity: zero acts as one, and it saturates at the entry count.
  always_comb begin
    eff_cap = 32'(capacity);
    if (eff_cap == 32'd0) begin
      eff_cap = 32'd1;
    end
    if (eff_cap > 32'(ENTRIES)) begin
      eff_cap = 32'(ENTRIES);
    end
  end

  assign full = (32'(occupancy) >= eff_cap);

  // Lowest free slot: lowest clear bit of the valid vector.
  assign free_vec = ~valid & (valid + ENTRIES'(1));

  // Valid ranks always form 0 .. occupancy-1, so the victim holds the highest one.
  assign last_rank = RANK_W'(occupancy - OCC_W'(1));

  always_comb begin
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      victim_vec[i] = valid[i] && (rank[i] == last_rank);
      hit_rank      = hit_rank | (rank[i] & {RANK_W{hit_vec[i]}});
    end
  end

  // Slot written by the set: the hit entry, else a free slot, else the victim.
  assign slot_vec = hit ? hit_vec : (full ? victim_vec : free_vec);

  // Entries that move one step down in recency.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      inc_vec[i] = !slot_vec[i] && valid[i] && (!hit || (rank[i] < hit_rank));
    end
  end

  // Control state: valid bits, ranks and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      rank      <= '0;
      occupancy <= '0;
    end else if (upd_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_vec[i]) begin
          valid[i] <= 1'b1;
          rank[i]  <= '0;
        end else if (inc_vec[i]) begin
          rank[i] <= rank[i] + RANK_W'(1);
        end
      end
      if (!hit && !full) begin
        occupancy <= occupancy + OCC_W'(1);
      end
    end
  end

  // Key and value storage.
  always_ff @(posedge clk) begin
    if (upd_en) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot_vec[i]) begin
          entry_key[i]   <= upd_key;
          entry_value[i] <= upd_value;
        end
      end
    end
  end

  assign entry_valid = valid;

`ifndef ASSERT_OFF
  // The occupancy count tracks the number of valid entries.
  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    $countones(valid) == int'(occupancy))
    else $error("occupancy does not match valid entries");

  // A set always writes exactly one slot.
  a_slot_onehot: assert property (@(posedge clk) disable iff (rst)
    upd_en |-> $onehot(slot_vec))
    else $error("set does not select exactly one slot");

  // An insert into a free slot raises occupancy by one.
  a_occ_grow: assert property (@(posedge clk) disable iff (rst)
    (upd_en && !hit && !full) |=> (occupancy == $past(occupancy) + OCC_W'(1)))
    else $error("occupancy did not grow on insert");
`endif

endmodule

// File: rtl/core/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache: command and result
// registers, capacity register, lookup and storage. Depends on lkv_pkg,
// lkv_lookup and lkv_store.
//
//   Channel   Ports                     Direction  Handshake
//   command   start, busy, cmd          in         start && !busy
//   result    result_valid, result      out        one-cycle strobe
//   config    cfg_we, cfg_wdata         in         cfg_we
//
// A command enters the command register at the accepting edge; the lookup and
// the entry update run in the next cycle, and a get's result is captured in the
// result register at the end of that cycle. One command per cycle is taken while
// rst is low. A set gives no result. Synchronous reset clears valid bits, ranks
// and occupancy; busy is high only while rst is asserted. The result side cannot stall.
`timescale 1ns / 1ps

module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lkv_pkg::lkv_cmd_t             cmd,
  output logic                          result_valid,
  output lkv_pkg::lkv_result_t          result,
  input  logic                          cfg_we,
  input  logic [lkv_pkg::CAP_W-1:0]     cfg_wdata
);

  logic                                   req_valid;
  lkv_pkg::lkv_cmd_t                      req;
  logic [lkv_pkg::CAP_W-1:0]              capacity;

  logic [ENTRIES-1:0]                     entry_valid;
  logic [ENTRIES-1:0][lkv_pkg::DATA_W-1:0] entry_key;
  logic [ENTRIES-1:0][lkv_pkg::DATA_W-1:0] entry_value;
  logic [ENTRIES-1:0]                     hit_vec;
  logic                                   hit;
  logic [lkv_pkg::DATA_W-1:0]             read_value;
  logic                                   upd_en;

  assign busy = rst;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // Command register.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req <= cmd;
    end
  end

  // Key match over all entries.
  lkv_lookup #(
    .ENTRIES (ENTRIES)
  ) u_lookup (
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .key         (req.key),
    .hit_vec     (hit_vec),
    .hit         (hit),
    .read_value  (read_value)
  );

  assign upd_en = req_valid && (req.action == lkv_pkg::ACT_SET);

  // Entry storage and recency update.
  lkv_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .upd_en      (upd_en),
    .upd_key     (req.key),
    .upd_value   (req.value),
    .hit         (hit),
    .hit_vec     (hit_vec),
    .capacity    (capacity),
    .entry_valid (entry_valid),
    .entry_key   (entry_key),
    .entry_value (entry_value)
  );

  // Result register: a get produces one result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= req_valid && (req.action == lkv_pkg::ACT_GET);
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      result.hit        <= hit;
      result.read_value <= read_value;
    end
  end

`ifndef ASSERT_OFF
  // At most one entry matches any key.
  a_hit_onehot0: assert property (@(posedge clk) disable iff (rst)
    req_valid |-> $onehot0(hit_vec))
    else $error("key matched more than one entry");

  // A result follows only a registered get.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(req_valid && (req.action == lkv_pkg::ACT_GET)))
    else $error("result without a get");

  // A miss always reports the miss value.
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |-> (result.read_value == lkv_pkg::MISS_VALUE))
    else $error("miss result carries a stored value");
`endif

endmodule

// File: verif/lru_key_value_cache_tb.sv
// Self-checking testbench for the LRU key/value cache: directed table, then random phases.
// The phases change capacity and sender idling. Depends on lkv_pkg and lru_key_value_cache.
`timescale 1ns / 1ps

module lru_key_value_cache_tb;

  localparam int ENTRIES       = 16;
  localparam int KEY_POOL      = 24;
  localparam int ITEMS_PER_RUN = 160;
  localparam int DRAIN_CYCLES  = 8;
  localparam int CYCLE_LIMIT   = 200000;

  typedef enum logic {ROW_CMD, ROW_CAP} row_kind_t;

  // One row of the directed table: a command or a capacity write.
  typedef struct {
    row_kind_t                 kind;
    logic                      action;
    logic [31:0]               key;
    logic [31:0]               value;
    logic [lkv_pkg::CAP_W-1:0] cap;
    bit                        typed;
    logic                      exp_hit;
    logic [31:0]               exp_val;
  } stim_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  lkv_pkg::lkv_cmd_t         cmd = '0;
  logic                      result_valid;
  lkv_pkg::lkv_result_t      result;
  logic                      cfg_we = 1'b0;
  logic [lkv_pkg::CAP_W-1:0] cfg_wdata = '0;

  // Shadow copy of the cache contents and the capacity register.
  logic                      shadow_valid [ENTRIES];
  logic [31:0]               shadow_key   [ENTRIES];
  logic [31:0]               shadow_val   [ENTRIES];
  int unsigned               shadow_rank  [ENTRIES];
  int unsigned               shadow_occ = 0;
  logic [lkv_pkg::CAP_W-1:0] shadow_cap = lkv_pkg::CAP_RESET;

  lkv_pkg::lkv_result_t      pending_reads [$];
  bit                        read_typed = 1'b0;
  lkv_pkg::lkv_result_t      typed_result = '0;
  int                        error_count = 0;
  int                        cycle_count = 0;
  int                        sender_idle_pct = 0;
  logic [31:0]               key_pool [KEY_POOL];

  stim_row_t dir_table [22] = '{
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0005, 5'd0,  1'b1, 1'b0,
      lkv_pkg::MISS_VALUE},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h7FFF_FFFF, 32'h8000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0,  1'b1, 1'b1,
      32'h8000_0000},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h8000_0000, 32'h7FFF_FFFF, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h8000_0000, 32'hFFFF_FFFF, 5'd0,  1'b1, 1'b1,
      32'h7FFF_FFFF},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0,  1'b1, 1'b1,
      32'h0000_0000},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0,  1'b1, 1'b1,
      32'hFFFF_FFFF},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h1234_5678, 32'h0000_0000, 5'd0,  1'b1, 1'b0,
      lkv_pkg::MISS_VALUE},
    // Capacity zero acts as one, and it drops below the current occupancy.
    '{ROW_CAP, lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h0000_0001, 32'h0000_0064, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h8000_0000, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h0000_0001, 32'h0000_0000, 5'd0,  1'b1, 1'b1,
      32'h0000_0064},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h0000_0002, 32'h0000_00C8, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'hFFFF_FFFF, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    // Capacity above the entry count saturates.
    '{ROW_CAP, lkv_pkg::ACT_GET, 32'h0000_0000, 32'h0000_0000, 5'd31, 1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h0000_0003, 32'h0000_012C, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_SET, 32'h0000_0004, 32'h0000_0190, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h0000_0002, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h0000_0003, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0},
    '{ROW_CMD, lkv_pkg::ACT_GET, 32'h7FFF_FFFF, 32'h0000_0000, 5'd0,  1'b0, 1'b0, 32'h0}
  };

  int unsigned cap_sched [10] = '{16, 1, 4, 0, 31, 8, 2, 17, 5, 16};

  lru_key_value_cache #(.ENTRIES(ENTRIES)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result_valid (result_valid),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Move slot s to the front; every valid entry ranked below the limit drops one place.
  task automatic lru_promote(input int s, input int unsigned limit);
    for (int i = 0; i < ENTRIES; i++) begin
      if (i != s && shadow_valid[i] && shadow_rank[i] < limit) shadow_rank[i]++;
    end
    shadow_rank[s] = 0;
  endtask

  // Apply one command to the shadow cache and give the read result a get should return.
  task automatic lru_apply(input lkv_pkg::lkv_cmd_t c, output lkv_pkg::lkv_result_t rd);
    int          slot;
    int unsigned eff_cap;
    int unsigned best;
    bit          found;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == c.key) slot = i;
    end
    rd.hit        = (slot >= 0);
    rd.read_value = (slot >= 0) ? shadow_val[slot] : lkv_pkg::MISS_VALUE;
    if (c.action == lkv_pkg::ACT_GET) return;

    // Update of a present key.
    if (slot >= 0) begin
      shadow_val[slot] = c.value;
      lru_promote(slot, shadow_rank[slot]);
      return;
    end

    // Insert: take a free slot while below capacity, else evict the least recent.
    eff_cap = (shadow_cap == 0) ? 1 : ((shadow_cap > ENTRIES) ? ENTRIES : shadow_cap);
    if (shadow_occ < eff_cap) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !shadow_valid[i]) slot = i;
      end
    end
    if (slot < 0) begin
      found = 1'b0;
      best  = 0;
      slot  = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (shadow_valid[i] && (!found || shadow_rank[i] >= best)) begin
          best  = shadow_rank[i];
          slot  = i;
          found = 1'b1;
        end
      end
      shadow_valid[slot] = 1'b0;
    end else begin
      shadow_occ++;
    end
    shadow_valid[slot] = 1'b1;
    shadow_key[slot]   = c.key;
    shadow_val[slot]   = c.value;
    lru_promote(slot, 32'hFFFF_FFFF);
  endtask

  // Check results and track every accepted transfer at the rising edge.
  always @(posedge clk) begin
    lkv_pkg::lkv_result_t pred;
    lkv_pkg::lkv_result_t exp_res;
    if (!rst) begin
      if (cfg_we) shadow_cap = cfg_wdata;
      if (result_valid) begin
        if (pending_reads.size() == 0) begin
          $error("result transfer with no read outstanding");
          error_count++;
        end else begin
          exp_res = pending_reads.pop_front();
          if (result.hit !== exp_res.hit) begin
            $error("hit: expected %0d, actual %0d", exp_res.hit, result.hit);
            error_count++;
          end
          if (result.read_value !== exp_res.read_value) begin
            $error("read_value: expected %0h, actual %0h",
                   exp_res.read_value, result.read_value);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        lru_apply(cmd, pred);
        if (cmd.action == lkv_pkg::ACT_GET) begin
          pending_reads.push_back(read_typed ? typed_result : pred);
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Present one command after a random idle gap and hold it until the transfer.
  task automatic send_cmd(input lkv_pkg::lkv_cmd_t c, input bit typed,
                          input lkv_pkg::lkv_result_t exp_res);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    cmd          <= c;
    read_typed   = typed;
    typed_result = exp_res;
    do @(posedge clk); while (busy);
  endtask

  // Write capacity once the cache has gone quiet, including trailing set commands.
  task automatic write_capacity(input logic [lkv_pkg::CAP_W-1:0] cap);
    @(negedge clk);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= cap;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    lkv_pkg::lkv_cmd_t    c;
    lkv_pkg::lkv_result_t exp_res;
    int unsigned          span;
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_key[i]   = '0;
      shadow_val[i]   = '0;
      shadow_rank[i]  = 0;
    end
    // Extreme keys sit at the front of the pool so that small spans reuse them.
    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < KEY_POOL; i++) key_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (dir_table[r]) begin
      if (dir_table[r].kind == ROW_CAP) begin
        write_capacity(dir_table[r].cap);
      end else begin
        c.action              = dir_table[r].action;
        c.key                 = dir_table[r].key;
        c.value               = dir_table[r].value;
        exp_res.hit           = dir_table[r].exp_hit;
        exp_res.read_value    = dir_table[r].exp_val;
        send_cmd(c, dir_table[r].typed, exp_res);
      end
    end

    // Random phases: each sets a capacity and a sender idle rate.
    foreach (cap_sched[p]) begin
      write_capacity(cap_sched[p][lkv_pkg::CAP_W-1:0]);
      sender_idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 80 : 18);
      span = (cap_sched[p] == 0) ? 4 : ((cap_sched[p] > ENTRIES) ? 20 : cap_sched[p] + 3);
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        c.action = ($urandom_range(1) == 0) ? lkv_pkg::ACT_GET : lkv_pkg::ACT_SET;
        c.key    = ($urandom_range(99) < 80) ? key_pool[$urandom_range(span - 1)] : $urandom;
        c.value  = $urandom;
        send_cmd(c, 1'b0, '0);
      end
    end

    // Drain the outstanding reads, then let trailing commands settle.
    @(negedge clk);
    start <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
